@@ sv/bsrw_pkg.sv @@
`default_nettype none
package bsrw_pkg;

  // field widths
  localparam int SEQ_W      = 31;
  localparam int CNT_W      = 8;
  localparam int WIN_W      = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // register reset values
  localparam logic [CNT_W-1:0] BLOCK_SIZE_RST = 8'd8;
  localparam logic [WIN_W-1:0] WINDOW_RST     = 7'd8;

  // register word index (paddr[2])
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_WINDOW     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_UPDATE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;     // clearing pass: zero the slot under head_slot
    logic capture;    // input beat accepted
    logic classify;   // latch slot offset and pass-through count
    logic count_wr;   // write incremented counter back
    logic walk_rd;    // read counter at head slot
    logic walk_adv;   // clear head counter, advance head
    logic load_out;   // load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at last slot
    logic pass_thru;  // stale or beyond window
    logic complete;   // updated counter reached block size
    logic walk_stop;  // head counter incomplete or walk bound reached
    logic out_free;   // result register can take a beat
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/block_symbol_reassembly_window.sv @@
// flow: a stale or out-of-window block goes from accept through the check state to the result register;
//   an in-window symbol passes check, ring read and update, and one that completes a block walks the head
// a new item is accepted only once the result of the last one has been loaded into the result register;
//   the lookup, ring read, write-back and walk steps all share the single counter ring
// reset: clears the head, loads register defaults, then a clearing pass
//   zeroes every slot of the counter ring while input is held off
`default_nettype none
module block_symbol_reassembly_window #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bsrw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [bsrw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [bsrw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bsrw_pkg::SEQ_W-1:0]         block_seq,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [bsrw_pkg::SEQ_W-1:0]         ack_block_seq,
  output logic      [bsrw_pkg::CNT_W-1:0]         symbol_count,
  output logic      [bsrw_pkg::SEQ_W-1:0]         next_expected_block
);

  import bsrw_pkg::*;

  logic [CNT_W-1:0] block_size;
  logic [WIN_W-1:0] window_blocks;
  logic             cfg_wr;
  logic             reg_idx;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BLOCK_SIZE_RST;
      window_blocks <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLOCK_SIZE: block_size    <= pwdata[CNT_W-1:0];
        REG_WINDOW:     window_blocks <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_SIZE: prdata = {24'b0, block_size};
      REG_WINDOW:     prdata = {25'b0, window_blocks};
      default:        prdata = '0;
    endcase
  end

  bsrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bsrw_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .block_size          (block_size),
    .window_blocks       (window_blocks),
    .block_seq           (block_seq),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .ack_block_seq       (ack_block_seq),
    .symbol_count        (symbol_count),
    .next_expected_block (next_expected_block)
  );

endmodule
`default_nettype wire

@@ sv/bsrw_ram.sv @@
`default_nettype none
module bsrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/bsrw_ctrl.sv @@
`default_nettype none
module bsrw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire bsrw_pkg::dp_status_t  status,
  output bsrw_pkg::dp_cmd_t          cmd
);

  import bsrw_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.classify = 1'b1;
        state_next   = status.pass_thru ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.count_wr = 1'b1;
        if (status.complete) begin
          state_next = ST_WALK_RD;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (!status.walk_stop) begin
          cmd.walk_adv = 1'b1;
          state_next   = ST_WALK_RD;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/bsrw_dp.sv @@
`default_nettype none
module bsrw_dp #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bsrw_pkg::dp_cmd_t               cmd,
  output bsrw_pkg::dp_status_t                 status,
  input  wire logic [bsrw_pkg::CNT_W-1:0]      block_size,
  input  wire logic [bsrw_pkg::WIN_W-1:0]      window_blocks,
  input  wire logic [bsrw_pkg::SEQ_W-1:0]      block_seq,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bsrw_pkg::SEQ_W-1:0]      ack_block_seq,
  output logic      [bsrw_pkg::CNT_W-1:0]      symbol_count,
  output logic      [bsrw_pkg::SEQ_W-1:0]      next_expected_block
);

  import bsrw_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(RING_DEPTH + 1);
  localparam logic [31:0]   DEPTH32   = 32'(RING_DEPTH);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [SW-1:0] WALK_MAX  = SW'(RING_DEPTH);

  logic [SEQ_W-1:0] seq_reg;
  logic [SEQ_W-1:0] head_block;
  logic [AW-1:0]    head_slot;
  logic [AW-1:0]    slot;
  logic [CNT_W-1:0] count;
  logic [SW-1:0]    steps;

  logic [CNT_W-1:0] need;
  logic [31:0]      win;
  logic [31:0]      limit;
  logic             stale;
  logic             beyond;
  logic [SEQ_W-1:0] diff;
  logic [AW:0]      slot_sum;
  logic [AW-1:0]    slot_calc;
  logic [AW-1:0]    slot_inc;
  logic [CNT_W-1:0] rdata;
  logic [CNT_W-1:0] cnt_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;

  // effective block size and clamped window
  assign need  = (block_size == '0) ? CNT_W'(1) : block_size;
  assign win   = ({25'b0, window_blocks} > DEPTH32) ? DEPTH32 : {25'b0, window_blocks};

  // classify against head and window edge, no wrap on the edge
  assign limit  = {1'b0, head_block} + win;
  assign stale  = seq_reg < head_block;
  assign beyond = {1'b0, seq_reg} >= limit;
  assign diff   = seq_reg - head_block;

  // ring slot from head slot plus distance from head, one conditional subtract
  assign slot_sum  = {1'b0, head_slot} + {1'b0, diff[AW-1:0]};
  assign slot_calc = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : slot_sum[AW-1:0];

  // next head slot, back to zero after the last slot or when the block number wraps
  assign slot_inc = (head_slot == LAST_SLOT || head_block == '1) ? '0 : head_slot + 1'b1;

  // saturating counter increment
  assign cnt_inc = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;

  // counter ring port muxing
  always_comb begin
    ram_we    = cmd.clr_wr | cmd.count_wr | cmd.walk_adv;
    ram_waddr = cmd.count_wr ? slot : head_slot;
    ram_wdata = cmd.count_wr ? cnt_inc : '0;
    ram_raddr = cmd.walk_rd ? head_slot : slot_calc;
  end

  bsrw_ram #(
    .WIDTH (CNT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // head pointer and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      head_block <= '0;
      head_slot  <= '0;
    end else if (cmd.clr_wr) begin
      head_slot <= (head_slot == LAST_SLOT) ? '0 : head_slot + 1'b1;
    end else if (cmd.walk_adv) begin
      head_block <= head_block + 1'b1;
      head_slot  <= slot_inc;
    end
  end

  // walk step counter
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      steps <= '0;
    end else if (cmd.walk_adv) begin
      steps <= steps + 1'b1;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_reg <= block_seq;
    end
    if (cmd.classify) begin
      count <= stale ? block_size : '0;
    end
    if (cmd.count_wr) begin
      count <= cnt_inc;
    end
  end

  // slot held from read to write-back
  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      slot <= slot_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ack_block_seq       <= seq_reg;
      symbol_count        <= cmd.count_wr ? cnt_inc : count;
      next_expected_block <= head_block;
    end
  end

  // status to controller
  always_comb begin
    status.clr_last  = head_slot == LAST_SLOT;
    status.pass_thru = stale | beyond;
    status.complete  = cnt_inc >= need;
    status.walk_stop = (rdata < need) || (steps == WALK_MAX);
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ tb/block_symbol_reassembly_window_tb.sv @@
`timescale 1ns / 100ps
module block_symbol_reassembly_window_tb;
  import bsrw_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MIX_BEATS = 140;
  localparam int SATURATE_BEATS = 260;

  typedef struct {
    bit [SEQ_W-1:0] seq;
    bit [CNT_W-1:0] cnt;
    bit [SEQ_W-1:0] head;
  } ack_t;

  typedef enum {ROW_CFG, ROW_SYM} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic           reg_sel;
    bit [31:0]      value;
    bit             pinned;
    bit [CNT_W-1:0] want_count;
    bit [SEQ_W-1:0] want_head;
  } dir_row_t;

  typedef enum {RUN_MIX, RUN_SATURATE, RUN_SWEEP} run_kind_t;

  typedef struct {
    bit [7:0]  bs;
    bit [7:0]  win;
    run_kind_t kind;
  } setting_t;

  // directed rows, counts typed in where they follow directly from the rules
  dir_row_t plan [23] = '{
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd0,          1'b1, 8'd1,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd7,          1'b1, 8'd1,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd8,          1'b1, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'h7fff_ffff,  1'b1, 8'd0,   31'd0},
    '{ROW_CFG, REG_BLOCK_SIZE, 32'd1,          1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd0,          1'b1, 8'd2,   31'd1},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd0,          1'b1, 8'd1,   31'd1},
    '{ROW_CFG, REG_BLOCK_SIZE, 32'd0,          1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd0,          1'b1, 8'd0,   31'd1},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd1,          1'b1, 8'd1,   31'd2},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd2,          1'b1, 8'd1,   31'd3},
    '{ROW_CFG, REG_WINDOW,     32'd0,          1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd3,          1'b1, 8'd0,   31'd3},
    '{ROW_CFG, REG_WINDOW,     32'd127,        1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd66,         1'b1, 8'd1,   31'd3},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd67,         1'b1, 8'd0,   31'd3},
    '{ROW_CFG, REG_WINDOW,     32'd1,          1'b0, 8'd0,   31'd0},
    '{ROW_CFG, REG_BLOCK_SIZE, 32'd255,        1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd3,          1'b1, 8'd1,   31'd3},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd4,          1'b1, 8'd0,   31'd3},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd2,          1'b1, 8'd255, 31'd3},
    '{ROW_CFG, REG_BLOCK_SIZE, 32'd2,          1'b0, 8'd0,   31'd0},
    '{ROW_SYM, REG_BLOCK_SIZE, 32'd3,          1'b1, 8'd2,   31'd4}
  };

  // register settings for the random part, four per idling phase
  setting_t settings [12] = '{
    '{8'd3,   8'd8,   RUN_MIX},
    '{8'd255, 8'd8,   RUN_SATURATE},
    '{8'd1,   8'd64,  RUN_SWEEP},
    '{8'd0,   8'd4,   RUN_MIX},
    '{8'd2,   8'd127, RUN_MIX},
    '{8'd1,   8'd1,   RUN_MIX},
    '{8'd4,   8'd0,   RUN_MIX},
    '{8'd6,   8'd16,  RUN_MIX},
    '{8'd8,   8'd65,  RUN_MIX},
    '{8'd5,   8'd63,  RUN_MIX},
    '{8'd1,   8'd127, RUN_SWEEP},
    '{8'd7,   8'd32,  RUN_MIX}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SEQ_W-1:0]      block_seq = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEQ_W-1:0]      ack_block_seq;
  logic [CNT_W-1:0]      symbol_count;
  logic [SEQ_W-1:0]      next_expected_block;

  // typed-in expectation riding along with the input beat
  logic                  pin_valid = 1'b0;
  logic [CNT_W-1:0]      pin_count = '0;
  logic [SEQ_W-1:0]      pin_head = '0;

  // shadow of the block state and registers
  bit [CNT_W-1:0] ring_cnt [RING_DEPTH];
  bit [SEQ_W-1:0] ring_head = '0;
  bit [CNT_W-1:0] cfg_block_size = BLOCK_SIZE_RST;
  bit [WIN_W-1:0] cfg_window = WINDOW_RST;

  ack_t           ack_q [$];
  int             acks_pending = 0;
  bit [SEQ_W-1:0] head_hint = '0;
  int             tx_idle = 34;
  int             rx_idle = 48;
  int             errors = 0;
  int             cycles = 0;

  block_symbol_reassembly_window #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .block_seq           (block_seq),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .ack_block_seq       (ack_block_seq),
    .symbol_count        (symbol_count),
    .next_expected_block (next_expected_block)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // count one symbol against the shadow ring and walk the head
  function automatic ack_t score_symbol(input bit [SEQ_W-1:0] seq);
    ack_t        r;
    bit [CNT_W-1:0] need;
    int          win;
    int          slot;
    int          walked;
    need = (cfg_block_size == 8'd0) ? 8'd1 : cfg_block_size;
    win = (cfg_window > RING_DEPTH) ? RING_DEPTH : int'(cfg_window);
    r.seq = seq;
    if (seq < ring_head) begin
      r.cnt = cfg_block_size;
    end else if (longint'(seq) >= longint'(ring_head) + win) begin
      r.cnt = 8'd0;
    end else begin
      slot = seq % RING_DEPTH;
      if (ring_cnt[slot] != CNT_MAX) ring_cnt[slot] = ring_cnt[slot] + 8'd1;
      r.cnt = ring_cnt[slot];
      if (r.cnt >= need) begin
        walked = 0;
        while (walked < RING_DEPTH && ring_cnt[ring_head % RING_DEPTH] >= need) begin
          ring_cnt[ring_head % RING_DEPTH] = 8'd0;
          ring_head = ring_head + 31'd1;
          walked++;
        end
      end
    end
    r.head = ring_head;
    return r;
  endfunction

  // random block number: noise, stale, beyond window, or in window near the head
  function automatic bit [SEQ_W-1:0] pick_seq(input bit [SEQ_W-1:0] hh, input int span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return 31'($urandom);
    if (roll < 27 && hh != 31'd0) return hh - 31'($urandom_range(hh > 16 ? 16 : hh, 1));
    if (roll < 37 || span == 0) return hh + 31'(span) + 31'($urandom_range(5));
    if (roll < 70) return hh + 31'($urandom_range(span > 4 ? 3 : span - 1));
    return hh + 31'($urandom_range(span - 1));
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 50) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // drop valid and wait until every ack has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (acks_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input bit [7:0] val);
    bit [31:0] word;
    wait_idle();
    word = {24'($urandom), val};
    if (sel == REG_WINDOW) word[7] = 1'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_BLOCK_SIZE) cfg_block_size = val;
    else cfg_window = val[WIN_W-1:0];
  endtask

  // present one symbol beat and hold it until accepted
  task automatic send_symbol(input bit [SEQ_W-1:0] seq, input bit pinned,
                             input bit [CNT_W-1:0] pc, input bit [SEQ_W-1:0] ph);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    block_seq <= seq;
    pin_valid <= pinned;
    pin_count <= pc;
    pin_head  <= ph;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // ack side backpressure
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= rx_idle);
  end

  // scoreboard: retire acks first, then book the new symbol
  always @(posedge clk) begin : track
    ack_t want;
    ack_t fresh;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (ack_q.size() == 0) begin
          report_mismatch($sformatf("unexpected ack for block %0d", ack_block_seq));
        end else begin
          want = ack_q.pop_front();
          if (ack_block_seq !== want.seq)
            report_mismatch($sformatf("ack_block_seq %0d, want %0d", ack_block_seq, want.seq));
          if (symbol_count !== want.cnt)
            report_mismatch($sformatf("symbol_count %0d for block %0d, want %0d",
                                      symbol_count, want.seq, want.cnt));
          if (next_expected_block !== want.head)
            report_mismatch($sformatf("next_expected_block %0d for block %0d, want %0d",
                                      next_expected_block, want.seq, want.head));
        end
      end
      if (in_valid && in_ready) begin
        fresh = score_symbol(block_seq);
        if (pin_valid) begin
          fresh.cnt  = pin_count;
          fresh.head = pin_head;
        end
        ack_q = {ack_q, fresh};
      end
    end
    acks_pending <= ack_q.size();
    head_hint    <= ring_head;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL block_symbol_reassembly_window");
      $finish;
    end
  end

  initial begin : stimulus
    int             order [RING_DEPTH-1];
    int             j;
    int             tmp;
    int             span;
    bit [SEQ_W-1:0] base;
    setting_t       s;

    settings[7].bs  = 8'($urandom_range(8, 1));
    settings[7].win = 8'($urandom_range(127));
    settings[11].bs  = 8'($urandom_range(255));
    settings[11].win = 8'($urandom_range(127));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG)
        write_reg(plan[r].reg_sel, plan[r].value[7:0]);
      else
        send_symbol(plan[r].value[SEQ_W-1:0], plan[r].pinned,
                    plan[r].want_count, plan[r].want_head);
    end

    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 34 : (ph == 1) ? 48 : 0;
      rx_idle <= (ph == 0) ? 48 : (ph == 1) ? 34 : 0;
      for (int k = 0; k < 4; k++) begin
        s = settings[ph * 4 + k];
        write_reg(REG_BLOCK_SIZE, s.bs);
        write_reg(REG_WINDOW, s.win);
        wait_idle();
        case (s.kind)
          RUN_SATURATE: begin
            // hammer the block just ahead of the head past the counter ceiling
            base = head_hint + 31'd1;
            repeat (SATURATE_BEATS) send_symbol(base, 1'b0, 8'd0, 31'd0);
          end
          RUN_SWEEP: begin
            // settle the head, fill every other slot, then complete the head
            send_symbol(head_hint, 1'b0, 8'd0, 31'd0);
            wait_idle();
            base = head_hint;
            for (int i = 0; i < RING_DEPTH - 1; i++) order[i] = i + 1;
            for (int i = RING_DEPTH - 2; i > 0; i--) begin
              j = $urandom_range(i);
              tmp = order[i];
              order[i] = order[j];
              order[j] = tmp;
            end
            foreach (order[i]) send_symbol(base + 31'(order[i]), 1'b0, 8'd0, 31'd0);
            send_symbol(base, 1'b0, 8'd0, 31'd0);
          end
          default: begin
            span = (cfg_window > RING_DEPTH) ? RING_DEPTH : int'(cfg_window);
            repeat (MIX_BEATS) send_symbol(pick_seq(head_hint, span), 1'b0, 8'd0, 31'd0);
          end
        endcase
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS block_symbol_reassembly_window");
    end else begin
      $display("FAIL block_symbol_reassembly_window");
    end
    $finish;
  end

endmodule
